FILE: design/aesc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesc_pkg
// Shared constants, types and the UTF-8 rune check of the escape stripper.
// ----------------------------------------------------------------------------
package aesc_pkg;

  localparam int MAX_PENDING = 48;
  localparam int RUNE_BYTES  = 4;
  localparam int BUF_DEPTH   = 64;
  localparam int PTR_W       = $clog2(BUF_DEPTH);
  localparam int CNT_W       = 6;
  localparam int HCNT_W      = 3;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SO    = 8'h0E;
  localparam logic [7:0] CH_SI    = 8'h0F;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_RBR   = 8'h5D;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_HI    = 8'h80;

  localparam logic [3:0] PH_TEXT      = 4'd0;
  localparam logic [3:0] PH_ESC       = 4'd1;
  localparam logic [3:0] PH_CSI       = 4'd2;
  localparam logic [3:0] PH_OSC_DIGIT = 4'd3;
  localparam logic [3:0] PH_OSC_SEMI  = 4'd4;
  localparam logic [3:0] PH_OSC_FIRST = 4'd5;
  localparam logic [3:0] PH_OSC_BODY  = 4'd6;
  localparam logic [3:0] PH_OSC_ESC   = 4'd7;
  localparam logic [3:0] PH_RUNE      = 4'd8;

  typedef logic [RUNE_BYTES-1:0][7:0] bytes_t;

  // A cleared struct means a valid rune that is not complete yet.
  typedef struct packed {
    logic       invalid;
    logic [2:0] len;
  } rune_st_t;

  typedef struct packed {
    logic accept;
    logic rd;
    logic proc;
    logic endres;
    logic flush;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic can_emit;
    logic need_flush;
    logic held_any;
    logic more_n;
    logic seq_n;
    logic held_n;
    logic last;
  } sts_t;

  function automatic rune_st_t rune_status(input bytes_t b, input logic [CNT_W-1:0] n,
                                           input logic utf8);
    rune_st_t   st;
    logic [7:0] lead;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] l2;
    logic [7:0] h2;
    logic [2:0] len;
    logic       bad;
    st   = '0;
    lead = b[0];
    lo   = 8'h80;
    hi   = 8'hBF;
    len  = 3'd1;
    bad  = 1'b0;
    if (lead >= CH_HI) begin
      if (!utf8) begin
        bad = 1'b1;
      end
      if (lead >= 8'hC2 && lead <= 8'hDF) begin
        len = 3'd2;
      end else if (lead >= 8'hE0 && lead <= 8'hEF) begin
        len = 3'd3;
      end else if (lead >= 8'hF0 && lead <= 8'hF4) begin
        len = 3'd4;
      end else begin
        bad = 1'b1;
      end
      if (int'(len) > RUNE_BYTES) begin
        bad = 1'b1;
      end
      if (lead == 8'hE0) lo = 8'hA0;
      if (lead == 8'hED) hi = 8'h9F;
      if (lead == 8'hF0) lo = 8'h90;
      if (lead == 8'hF4) hi = 8'h8F;
      for (int i = 1; i < RUNE_BYTES; i++) begin
        l2 = (i == 1) ? lo : 8'h80;
        h2 = (i == 1) ? hi : 8'hBF;
        if (i < int'(len) && i < int'(n) && (b[i] < l2 || b[i] > h2)) begin
          bad = 1'b1;
        end
      end
    end
    if (n == '0) begin
      st = '0;
    end else if (bad) begin
      st.invalid = 1'b1;
    end else if (n < CNT_W'(len)) begin
      st = '0;
    end else begin
      st.len = len;
    end
    return st;
  endfunction

endpackage

FILE: design/aesc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module aesc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/aesc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesc_ctrl
// Sequencer of the escape stripper: accept, read, process, resolve, flush, finish.
// ----------------------------------------------------------------------------
module aesc_ctrl
  import aesc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_PROC  = 3'd2;
  localparam logic [2:0] S_ENDR  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state_q;
  logic [2:0] state_d;
  logic [2:0] after;

  // Where to go once the current byte and its side effects are done.
  always_comb begin
    if (sts_i.more_n) begin
      after = S_READ;
    end else if (sts_i.last && sts_i.seq_n) begin
      after = S_ENDR;
    end else if (sts_i.last && sts_i.held_n) begin
      after = S_FLUSH;
    end else begin
      after = S_FIN;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_PROC;
      end
      S_PROC: begin
        if (sts_i.can_emit) begin
          cmd_o.proc = 1'b1;
          state_d    = sts_i.need_flush ? S_FLUSH : after;
        end
      end
      S_ENDR: begin
        if (sts_i.can_emit) begin
          cmd_o.endres = 1'b1;
          state_d      = sts_i.need_flush ? S_FLUSH : after;
        end
      end
      S_FLUSH: begin
        if (sts_i.held_any) begin
          cmd_o.flush = sts_i.can_emit;
        end else begin
          state_d = after;
        end
      end
      S_FIN: begin
        if (sts_i.can_emit) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

FILE: design/aesc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesc_dp
// Datapath: byte buffer, sequence parser, held tail and output staging.
// ----------------------------------------------------------------------------
module aesc_dp
  import aesc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       out_ready_i,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       run_last_o,
  output logic       text_end_o
);

  logic              utf8_q;
  logic [PTR_W-1:0]  w_q, w_d, r_q, r_d, s_q, s_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [3:0]        phase_q, phase_d;
  bytes_t            rb_q, rb_d, held_q, held_d;
  logic [HCNT_W-1:0] hcnt_q, hcnt_d;
  logic              fresh_q, fresh_d, nl_q, nl_d, last_q, last_d;
  logic              stg_v_q, stg_v_d;
  logic [7:0]        stg_b_q, stg_b_d;
  logic              out_v_q, out_v_d;
  logic [7:0]        out_b_q, out_b_d;
  logic              out_bv_q, out_bv_d, out_rl_q, out_rl_d, out_te_q, out_te_d;

  logic [7:0]        c;
  bytes_t            mrg, kheld, fshift;
  logic [7:0]        kb;
  logic              full;
  logic [HCNT_W-1:0] kcnt, lb;
  bytes_t            res_arr;
  logic [CNT_W-1:0]  res_len, res_nn;
  rune_st_t          rs;
  logic              rkeep;
  logic [2:0]        rr;
  logic [PTR_W-1:0]  r_new;
  logic              emit_v;
  logic [7:0]        emit_b;
  logic              removal, do_keep, do_res, succ, app, fail;
  logic [3:0]        ph_n;
  logic              can_emit;

  aesc_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (cmd_i.accept),
    .waddr_i(w_q),
    .wdata_i(in_byte_i),
    .re_i   (cmd_i.rd),
    .raddr_i(r_q),
    .rdata_o(c)
  );

  // Length of the rune that ends the held tail; a broken rune counts as one byte.
  function automatic logic [HCNT_W-1:0] lookback(input bytes_t h, input logic [HCNT_W-1:0] n,
                                                 input logic utf8);
    logic [7:0]        lastb;
    logic              fnd;
    logic [HCNT_W-1:0] fk;
    logic [HCNT_W-1:0] len;
    bytes_t            sh;
    rune_st_t          st;
    logic [HCNT_W-1:0] res;
    lastb = h[0];
    fnd   = 1'b0;
    fk    = '0;
    res   = HCNT_W'(1);
    for (int j = 0; j < RUNE_BYTES; j++) begin
      if (n == HCNT_W'(j + 1)) lastb = h[j];
    end
    for (int k = 0; k < RUNE_BYTES - 1; k++) begin
      if (HCNT_W'(k + 2) <= n && h[k][7:6] != 2'b10) begin
        fnd = 1'b1;
        fk  = HCNT_W'(k);
      end
    end
    len = n - fk;
    sh  = bytes_t'(h >> {fk, 3'b000});
    st  = rune_status(sh, CNT_W'(len), utf8);
    if (lastb >= CH_HI && utf8 && fnd && !st.invalid && st.len == len) begin
      res = len;
    end
    return res;
  endfunction

  assign can_emit = !out_v_q || out_ready_i;

  // Bytes after the ESC with the byte in hand merged in at its offset.
  always_comb begin
    mrg = rb_q;
    for (int j = 0; j < RUNE_BYTES; j++) begin
      if (cnt_q == CNT_W'(j + 1)) mrg[j] = c;
    end
  end

  // Appending to the held tail; when full the oldest byte leaves for output.
  always_comb begin
    kb   = (phase_q == PH_TEXT && !cmd_i.endres) ? c : CH_ESC;
    full = (hcnt_q == HCNT_W'(RUNE_BYTES));
    if (full) begin
      kheld                 = bytes_t'(held_q >> 8);
      kheld[RUNE_BYTES - 1] = kb;
      kcnt                  = hcnt_q;
    end else begin
      kheld = held_q;
      for (int j = 0; j < RUNE_BYTES; j++) begin
        if (hcnt_q == HCNT_W'(j)) kheld[j] = kb;
      end
      kcnt = hcnt_q + HCNT_W'(1);
    end
    fshift = bytes_t'(held_q >> 8);
    lb     = lookback(held_q, hcnt_q, utf8_q);
  end

  // Fallback of a failed match: ESC plus rune removed, or ESC kept as text.
  always_comb begin
    if (cmd_i.endres) begin
      res_arr = rb_q;
      res_len = cnt_q - CNT_W'(1);
      res_nn  = cnt_q;
    end else begin
      res_arr = mrg;
      res_len = cnt_q;
      res_nn  = cnt_q + CNT_W'(1);
    end
    rs    = rune_status(res_arr, res_len, utf8_q);
    rkeep = (res_nn < CNT_W'(2)) || (res_arr[0] == CH_NL);
    rr    = (res_arr[0] >= CH_HI && !rs.invalid && rs.len != 3'd0) ? rs.len : 3'd1;
    r_new = rkeep ? s_q + PTR_W'(1) : s_q + PTR_W'(1) + PTR_W'(rr);
  end

  always_comb begin
    w_d     = w_q;
    r_d     = r_q;
    s_d     = s_q;
    cnt_d   = cnt_q;
    phase_d = phase_q;
    rb_d    = rb_q;
    held_d  = held_q;
    hcnt_d  = hcnt_q;
    fresh_d = fresh_q;
    nl_d    = nl_q;
    last_d  = last_q;
    emit_v  = 1'b0;
    emit_b  = held_q[0];
    removal = 1'b0;
    do_keep = 1'b0;
    do_res  = 1'b0;
    succ    = 1'b0;
    app     = 1'b0;
    fail    = 1'b0;
    ph_n    = phase_q;

    if (cmd_i.accept) begin
      w_d    = w_q + PTR_W'(1);
      last_d = in_last_i;
    end

    if (cmd_i.proc) begin
      if (phase_q == PH_TEXT) begin
        r_d = r_q + PTR_W'(1);
        if (c == CH_ESC) begin
          s_d     = r_q;
          cnt_d   = CNT_W'(1);
          phase_d = PH_ESC;
        end else if (c == CH_SO || c == CH_SI) begin
          removal = 1'b1;
        end else if (c == CH_BS && !fresh_q && !nl_q && hcnt_q != '0) begin
          hcnt_d  = hcnt_q - lb;
          removal = 1'b1;
        end else begin
          do_keep = 1'b1;
        end
      end else if (cnt_q >= CNT_W'(MAX_PENDING)) begin
        fail = 1'b1;
      end else begin
        case (phase_q)
          PH_ESC: begin
            if (c == CH_NL) begin
              fail = 1'b1;
            end else if (c == CH_BSL || c == CH_LBR || c == CH_LPAR || c == CH_RPAR) begin
              app  = 1'b1;
              ph_n = PH_CSI;
            end else if (c == CH_RBR) begin
              app  = 1'b1;
              ph_n = PH_OSC_DIGIT;
            end else if (c < CH_HI) begin
              succ = 1'b1;
            end else if (rs.invalid) begin
              fail = 1'b1;
            end else if (rs.len != 3'd0) begin
              succ = 1'b1;
            end else begin
              app  = 1'b1;
              ph_n = PH_RUNE;
            end
          end
          PH_RUNE: begin
            if (rs.invalid) begin
              fail = 1'b1;
            end else if (rs.len != 3'd0) begin
              succ = 1'b1;
            end else begin
              app = 1'b1;
            end
          end
          PH_CSI: begin
            if ((c >= CH_0 && c <= CH_9) || c == CH_SEMI) begin
              app = 1'b1;
            end else if ((c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ)
                         || c == CH_AT) begin
              succ = 1'b1;
            end else begin
              fail = 1'b1;
            end
          end
          PH_OSC_DIGIT: begin
            if (c >= CH_0 && c <= CH_9) begin
              app  = 1'b1;
              ph_n = PH_OSC_SEMI;
            end else begin
              fail = 1'b1;
            end
          end
          PH_OSC_SEMI: begin
            if (c == CH_SEMI) begin
              app  = 1'b1;
              ph_n = PH_OSC_FIRST;
            end else begin
              fail = 1'b1;
            end
          end
          PH_OSC_FIRST: begin
            if (c >= CH_SP && c <= CH_TILDE) begin
              app  = 1'b1;
              ph_n = PH_OSC_BODY;
            end else begin
              fail = 1'b1;
            end
          end
          PH_OSC_BODY: begin
            if (c >= CH_SP && c <= CH_TILDE) begin
              app = 1'b1;
            end else if (c == CH_BEL) begin
              succ = 1'b1;
            end else if (c == CH_ESC) begin
              app  = 1'b1;
              ph_n = PH_OSC_ESC;
            end else begin
              fail = 1'b1;
            end
          end
          PH_OSC_ESC: begin
            if (c == CH_BSL) begin
              succ = 1'b1;
            end else begin
              fail = 1'b1;
            end
          end
          default: begin
            fail = 1'b1;
          end
        endcase
      end
    end

    if (cmd_i.endres || fail) begin
      do_res = 1'b1;
    end

    if (app) begin
      rb_d    = mrg;
      cnt_d   = cnt_q + CNT_W'(1);
      phase_d = ph_n;
      r_d     = r_q + PTR_W'(1);
    end

    if (succ) begin
      cnt_d   = '0;
      phase_d = PH_TEXT;
      r_d     = r_q + PTR_W'(1);
      removal = 1'b1;
    end

    // The failing byte and everything after the removed part is read again.
    if (do_res) begin
      cnt_d   = '0;
      phase_d = PH_TEXT;
      r_d     = r_new;
      if (rkeep) begin
        do_keep = 1'b1;
      end else begin
        removal = 1'b1;
      end
    end

    if (do_keep) begin
      held_d  = kheld;
      hcnt_d  = kcnt;
      emit_v  = full;
      fresh_d = 1'b0;
      nl_d    = (kb == CH_NL);
    end

    if (removal) begin
      fresh_d = 1'b1;
      nl_d    = 1'b0;
    end

    if (cmd_i.flush && hcnt_q != '0) begin
      emit_v = 1'b1;
      held_d = fshift;
      hcnt_d = hcnt_q - HCNT_W'(1);
    end

    if (cmd_i.fin && last_q) begin
      fresh_d = 1'b1;
      nl_d    = 1'b0;
    end
  end

  // The newest emitted byte waits in a stage until it is known whether it ends the run.
  always_comb begin
    stg_v_d  = stg_v_q;
    stg_b_d  = stg_b_q;
    out_v_d  = out_v_q && !out_ready_i;
    out_b_d  = out_b_q;
    out_bv_d = out_bv_q;
    out_rl_d = out_rl_q;
    out_te_d = out_te_q;
    if (emit_v) begin
      if (stg_v_q) begin
        out_v_d  = 1'b1;
        out_b_d  = stg_b_q;
        out_bv_d = 1'b1;
        out_rl_d = 1'b0;
        out_te_d = 1'b0;
      end
      stg_v_d = 1'b1;
      stg_b_d = emit_b;
    end
    if (cmd_i.fin) begin
      if (stg_v_q || last_q) begin
        out_v_d  = 1'b1;
        out_b_d  = stg_v_q ? stg_b_q : 8'h00;
        out_bv_d = stg_v_q;
        out_rl_d = 1'b1;
        out_te_d = last_q;
      end
      stg_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      utf8_q  <= 1'b1;
      w_q     <= '0;
      r_q     <= '0;
      s_q     <= '0;
      cnt_q   <= '0;
      phase_q <= PH_TEXT;
      hcnt_q  <= '0;
      fresh_q <= 1'b1;
      nl_q    <= 1'b0;
      last_q  <= 1'b0;
      stg_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        utf8_q <= cfg_wdata_i;
      end
      w_q     <= w_d;
      r_q     <= r_d;
      s_q     <= s_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
      hcnt_q  <= hcnt_d;
      fresh_q <= fresh_d;
      nl_q    <= nl_d;
      last_q  <= last_d;
      stg_v_q <= stg_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rb_q     <= rb_d;
    held_q   <= held_d;
    stg_b_q  <= stg_b_d;
    out_b_q  <= out_b_d;
    out_bv_q <= out_bv_d;
    out_rl_q <= out_rl_d;
    out_te_q <= out_te_d;
  end

  always_comb begin
    sts_o.can_emit   = can_emit;
    sts_o.need_flush = removal && (hcnt_d != '0)
                       || (do_keep && kb == CH_NL);
    sts_o.held_any   = (hcnt_q != '0);
    sts_o.more_n     = (r_d != w_q);
    sts_o.seq_n      = (phase_d != PH_TEXT);
    sts_o.held_n     = (hcnt_d != '0);
    sts_o.last       = last_q;
  end

  assign out_valid_o  = out_v_q;
  assign out_byte_o   = out_b_q;
  assign byte_valid_o = out_bv_q;
  assign run_last_o   = out_rl_q;
  assign text_end_o   = out_te_q;

endmodule

FILE: design/ansi_escape_stripper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_escape_stripper
// Removes terminal escape sequences, SO/SI and backspaced runes from a text.
// ----------------------------------------------------------------------------
// One input byte is handled at a time. A plain text byte goes through accept,
// a read of the byte buffer RAM, the parse step, and a closing step that
// marks the last result of the byte. Every byte re-read after a failed
// sequence match goes through a buffer read and a parse step again, and a
// sequence still open at the end of the text is resolved in a step of its own.
// Held bytes, after a removal, a newline or at the end of the text, are released
// one by one as the output takes them; the release ends when none are held.
// Results of one byte leave through a one-deep stage and an output register,
// so a slow consumer only pauses the parser. The rune mode bit may be written
// at any cycle while the block is idle.
module ansi_escape_stripper
  import aesc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       run_last_o,
  output logic       text_end_o
);

  cmd_t cmd;
  sts_t sts;

  aesc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  aesc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .byte_valid_o(byte_valid_o),
    .run_last_o  (run_last_o),
    .text_end_o  (text_end_o)
  );

endmodule

FILE: test/tb_ansi_escape_stripper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ansi_escape_stripper
// Self-checking bench for the escape stripper: a directed text and random
// escape-heavy texts in both rune modes are pushed through the block. The
// expected bytes are worked out by a bit-accurate predictor and compared in
// order with the output transfers, under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_ansi_escape_stripper
  import aesc_pkg::*;
();

  localparam int REPLAY_CAP = MAX_PENDING + 2;
  localparam int MAX_OUT    = MAX_PENDING + RUNE_BYTES + 1;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic [7:0] ob;
    bit         bv;
    bit         rl;
    bit         te;
  } text_out_t;

  class stripper_scoreboard;
    bit          utf8_mode = 1'b1;
    logic [7:0]  pend[MAX_PENDING];
    int          pend_n    = 0;
    logic [3:0]  phase     = PH_TEXT;
    logic [7:0]  held[$];
    bit          seg_fresh = 1'b1;
    bit          after_nl  = 1'b0;
    logic [7:0]  replay[$];
    text_out_t   step_out[$];
    text_out_t   expected_text[$];
    int          errors    = 0;
    int          n_in      = 0;
    int          n_out     = 0;
    int          n_texts   = 0;

    function byte_q_t tail(byte_q_t q, int from);
      byte_q_t r;
      for (int i = from; i < q.size(); i++) r.push_back(q[i]);
      return r;
    endfunction

    function byte_q_t pend_q();
      byte_q_t r;
      for (int i = 0; i < pend_n && i < MAX_PENDING; i++) r.push_back(pend[i]);
      return r;
    endfunction

    function void emit(logic [7:0] b);
      text_out_t t;
      t = '{b, 1'b1, 1'b0, 1'b0};
      if (step_out.size() < MAX_OUT) step_out.push_back(t);
    endfunction

    function void flush_held();
      foreach (held[i]) emit(held[i]);
      held.delete();
    endfunction

    function void removal();
      flush_held();
      seg_fresh = 1'b1;
      after_nl  = 1'b0;
    endfunction

    function void keep(logic [7:0] b);
      if (held.size() >= RUNE_BYTES) emit(held.pop_front());
      held.push_back(b);
      seg_fresh = 1'b0;
      after_nl  = (b == CH_NL);
      if (b == CH_NL) flush_held();
    endfunction

    // >0 complete rune length, 0 incomplete, -1 invalid
    function int rune_check(byte_q_t q);
      int         n;
      int         len;
      logic [7:0] lo;
      logic [7:0] hi;
      logic [7:0] l2;
      logic [7:0] h2;
      n  = q.size();
      lo = 8'h80;
      hi = 8'hBF;
      if (n < 1) return 0;
      if (q[0] < CH_HI) return 1;
      if (!utf8_mode) return -1;
      if (q[0] >= 8'hC2 && q[0] <= 8'hDF) len = 2;
      else if (q[0] >= 8'hE0 && q[0] <= 8'hEF) len = 3;
      else if (q[0] >= 8'hF0 && q[0] <= 8'hF4) len = 4;
      else return -1;
      if (len > RUNE_BYTES) return -1;
      if (q[0] == 8'hE0) lo = 8'hA0;
      if (q[0] == 8'hED) hi = 8'h9F;
      if (q[0] == 8'hF0) lo = 8'h90;
      if (q[0] == 8'hF4) hi = 8'h8F;
      for (int i = 1; i < len && i < n; i++) begin
        l2 = (i == 1) ? lo : 8'h80;
        h2 = (i == 1) ? hi : 8'hBF;
        if (q[i] < l2 || q[i] > h2) return -1;
      end
      return (n < len) ? 0 : len;
    endfunction

    // Length of the rune at the end of the held bytes.
    function int rune_behind();
      int c;
      c = held.size();
      if (c < 1) return 0;
      if (held[c-1] < CH_HI || !utf8_mode) return 1;
      for (int k = c - 2; k >= 0; k--) begin
        if ((held[k] & 8'hC0) != 8'h80)
          return (rune_check(tail(held, k)) == c - k) ? c - k : 1;
      end
      return 1;
    endfunction

    function void rescan(byte_q_t q);
      int n;
      n = q.size();
      if (n > REPLAY_CAP - replay.size()) n = REPLAY_CAP - replay.size();
      for (int i = n - 1; i >= 0; i--) replay.push_front(q[i]);
    endfunction

    // A failed match falls back to ESC plus one rune, or keeps the ESC.
    function void fall_back(byte_q_t q);
      int r;
      int s;
      r      = 1;
      pend_n = 0;
      phase  = PH_TEXT;
      if (q.size() < 1) return;
      if (q.size() < 2 || q[1] == CH_NL) begin
        keep(q[0]);
        rescan(tail(q, 1));
        return;
      end
      if (q[1] >= CH_HI) begin
        s = rune_check(tail(q, 1));
        if (s > 0) r = s;
      end
      removal();
      rescan(tail(q, 1 + r));
    endfunction

    function void fail_on(logic [7:0] c);
      byte_q_t q;
      q = pend_q();
      q.push_back(c);
      fall_back(q);
    endfunction

    function void matched();
      pend_n = 0;
      phase  = PH_TEXT;
      removal();
    endfunction

    function void add(logic [7:0] c);
      if (pend_n < MAX_PENDING) begin
        pend[pend_n] = c;
        pend_n++;
      end
    endfunction

    function void rune_progress();
      int s;
      s = rune_check(tail(pend_q(), 1));
      if (s > 0) matched();
      else if (s < 0) fall_back(pend_q());
    endfunction

    function bit printable(logic [7:0] c);
      return c >= CH_SP && c <= CH_TILDE;
    endfunction

    function bit digit(logic [7:0] c);
      return c >= CH_0 && c <= CH_9;
    endfunction

    function void parse(logic [7:0] c);
      int n;
      if (phase == PH_TEXT) begin
        if (c == CH_ESC) begin
          pend[0] = c;
          pend_n  = 1;
          phase   = PH_ESC;
        end else if (c == CH_SO || c == CH_SI) begin
          removal();
        end else if (c == CH_BS && !seg_fresh && !after_nl && held.size() > 0) begin
          n = rune_behind();
          repeat (n) void'(held.pop_back());
          removal();
        end else begin
          keep(c);
        end
        return;
      end
      if (pend_n >= MAX_PENDING) begin
        fail_on(c);
        return;
      end
      case (phase)
        PH_ESC: begin
          if (c == CH_NL) fail_on(c);
          else if (c == CH_BSL || c == CH_LBR || c == CH_LPAR || c == CH_RPAR) begin
            add(c);
            phase = PH_CSI;
          end else if (c == CH_RBR) begin
            add(c);
            phase = PH_OSC_DIGIT;
          end else if (c < CH_HI) matched();
          else begin
            add(c);
            phase = PH_RUNE;
            rune_progress();
          end
        end
        PH_RUNE: begin
          add(c);
          rune_progress();
        end
        PH_CSI: begin
          if (digit(c) || c == CH_SEMI) add(c);
          else if ((c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) || c == CH_AT)
            matched();
          else fail_on(c);
        end
        PH_OSC_DIGIT: begin
          if (digit(c)) begin
            add(c);
            phase = PH_OSC_SEMI;
          end else fail_on(c);
        end
        PH_OSC_SEMI: begin
          if (c == CH_SEMI) begin
            add(c);
            phase = PH_OSC_FIRST;
          end else fail_on(c);
        end
        PH_OSC_FIRST: begin
          if (printable(c)) begin
            add(c);
            phase = PH_OSC_BODY;
          end else fail_on(c);
        end
        PH_OSC_BODY: begin
          if (printable(c)) add(c);
          else if (c == CH_BEL) matched();
          else if (c == CH_ESC) begin
            add(c);
            phase = PH_OSC_ESC;
          end else fail_on(c);
        end
        PH_OSC_ESC: begin
          if (c == CH_BSL) matched();
          else fail_on(c);
        end
        default: fail_on(c);
      endcase
    endfunction

    function void note_input(logic [7:0] c, bit last);
      text_out_t t;
      n_in++;
      step_out.delete();
      replay.delete();
      replay.push_back(c);
      forever begin
        while (replay.size() > 0) parse(replay.pop_front());
        if (last && phase != PH_TEXT) fall_back(pend_q());
        else break;
      end
      if (last) begin
        n_texts++;
        flush_held();
        seg_fresh = 1'b1;
        after_nl  = 1'b0;
        if (step_out.size() == 0) begin
          t = '{8'h00, 1'b0, 1'b0, 1'b0};
          step_out.push_back(t);
        end
        step_out[step_out.size()-1].te = 1'b1;
      end
      if (step_out.size() > 0) step_out[step_out.size()-1].rl = 1'b1;
      foreach (step_out[i]) expected_text.push_back(step_out[i]);
    endfunction

    function void check_result(logic [7:0] ob, bit bv, bit rl, bit te);
      text_out_t e;
      n_out++;
      if (expected_text.size() == 0) begin
        $error("unexpected output transfer: out_byte=%h byte_valid=%b", ob, bv);
        errors++;
        return;
      end
      e = expected_text.pop_front();
      if (ob !== e.ob) begin
        $error("out_byte: expected %h, got %h", e.ob, ob);
        errors++;
      end
      if (bv !== e.bv) begin
        $error("byte_valid: expected %b, got %b", e.bv, bv);
        errors++;
      end
      if (rl !== e.rl) begin
        $error("run_last: expected %b, got %b", e.rl, rl);
        errors++;
      end
      if (te !== e.te) begin
        $error("text_end: expected %b, got %b", e.te, te);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_wdata_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] in_byte_i;
  logic       in_last_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       run_last_o;
  logic       text_end_o;

  stripper_scoreboard sb;
  int  tx_idle_pct = 29;
  int  rx_idle_pct = 63;
  bit  hold_off    = 1'b0;
  int  n_sent      = 0;

  ansi_escape_stripper dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .byte_valid_o(byte_valid_o),
    .run_last_o  (run_last_o),
    .text_end_o  (text_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        hold_off    = 1'b0;
        out_ready_i = 1'b0;
        repeat (400) @(negedge clk_i);
      end
      out_ready_i = ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(out_byte_o, byte_valid_o, run_last_o, text_end_o);
  end

  task automatic put(logic [7:0] b, bit last);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_byte_i  = b;
    in_last_i  = last;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    sb.note_input(b, last);
    n_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Random text byte; now and then it closes the text.
  task automatic put_r(logic [7:0] b);
    put(b, $urandom_range(0, 24) == 0);
  endtask

  task automatic put_rune();
    int k;
    k = $urandom_range(2, 4);
    case (k)
      2: put_r(8'($urandom_range(8'hC2, 8'hDF)));
      3: begin
        put_r(8'($urandom_range(8'hE0, 8'hEF)));
        put_r(8'($urandom_range(8'hA0, 8'h9F + 8'h20 * ($urandom_range(0, 1)))));
      end
      default: begin
        put_r(8'($urandom_range(8'hF0, 8'hF4)));
        put_r(8'($urandom_range(8'h90, 8'h8F + 8'h01)));
        put_r(8'($urandom_range(8'h80, 8'hBF)));
      end
    endcase
    put_r(8'($urandom_range(8'h80, 8'hBF)));
  endtask

  task automatic put_csi();
    logic [7:0] intro[4] = '{CH_BSL, CH_LBR, CH_LPAR, CH_RPAR};
    put_r(CH_ESC);
    put_r(intro[$urandom_range(0, 3)]);
    repeat ($urandom_range(0, 4))
      put_r(($urandom_range(0, 3) == 0) ? CH_SEMI : 8'($urandom_range(CH_0, CH_9)));
    case ($urandom_range(0, 5))
      0: put_r(CH_AT);
      1: put_r(8'($urandom_range(0, 255)));
      2: put_r(8'($urandom_range(CH_UA, CH_UZ)));
      default: put_r(8'($urandom_range(CH_LA, CH_LZ)));
    endcase
  endtask

  task automatic put_osc();
    put_r(CH_ESC);
    put_r(CH_RBR);
    put_r(($urandom_range(0, 7) == 0) ? CH_SEMI : 8'($urandom_range(CH_0, CH_9)));
    put_r(($urandom_range(0, 7) == 0) ? CH_NL : CH_SEMI);
    repeat ($urandom_range(1, 5)) put_r(8'($urandom_range(CH_SP, CH_TILDE)));
    case ($urandom_range(0, 4))
      0: begin
        put_r(CH_ESC);
        put_r(CH_BSL);
      end
      1: begin
        put_r(CH_ESC);
        put_r(8'($urandom_range(0, 255)));
      end
      2: put_r(8'($urandom_range(0, 255)));
      default: put_r(CH_BEL);
    endcase
  endtask

  // Escape sequences with random content, some of them malformed, and some noise.
  task automatic random_text(int target);
    int stop;
    stop = n_sent + target;
    while (n_sent < stop) begin
      case ($urandom_range(0, 12))
        0, 1: repeat ($urandom_range(1, 6)) put_r(8'($urandom_range(CH_SP, CH_TILDE)));
        2, 3: put_csi();
        4: put_osc();
        5: begin
          put_r(CH_ESC);
          if ($urandom_range(0, 1)) put_rune();
          else put_r(8'($urandom_range(0, 127)));
        end
        6: put_rune();
        7: put_r(($urandom_range(0, 1)) ? CH_SO : CH_SI);
        8: put_r(CH_BS);
        9: put_r(CH_NL);
        10: put_r(8'($urandom_range(0, 255)));
        11: begin
          put_r(CH_ESC);
          put_r(CH_NL);
        end
        default: begin
          // Rarely a sequence that overruns the pending store.
          if ($urandom_range(0, 5) == 0) begin
            put(CH_ESC, 1'b0);
            put(CH_LBR, 1'b0);
            repeat (MAX_PENDING + 2) put(8'($urandom_range(CH_0, CH_9)), 1'b0);
          end else begin
            put_r(8'($urandom_range(8'h80, 8'hFF)));
          end
        end
      endcase
    end
    put(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic drain_and_set_mode(bit mode);
    while (sb.expected_text.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = mode;
    sb.utf8_mode = mode;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  initial begin
    sb          = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    in_valid_i  = 1'b0;
    in_byte_i   = 8'h00;
    in_last_i   = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    drain_and_set_mode(1'b1);
    // Directed text: backspace at segment start, byte extremes, CSI, OSC, SO and
    // SI removal, a backspace over a multi-byte rune, ESC before newline, end flush.
    put(CH_BS, 1'b0);
    put(8'h00, 1'b0);
    put(8'hFF, 1'b0);
    put(CH_ESC, 1'b0);
    put(CH_LBR, 1'b0);
    put(CH_0 + 1, 1'b0);
    put(CH_SEMI, 1'b0);
    put(CH_LA + 12, 1'b0);
    put(CH_ESC, 1'b0);
    put(CH_RBR, 1'b0);
    put(CH_0, 1'b0);
    put(CH_SEMI, 1'b0);
    put(CH_TILDE, 1'b0);
    put(CH_BEL, 1'b0);
    put(CH_SO, 1'b0);
    put(CH_SI, 1'b0);
    put(CH_LA, 1'b0);
    put(8'hC3, 1'b0);
    put(8'hA9, 1'b0);
    put(CH_BS, 1'b0);
    put(CH_ESC, 1'b0);
    put(CH_NL, 1'b0);
    put(CH_BS, 1'b0);
    put(CH_ESC, 1'b0);
    put(CH_LBR, 1'b1);

    random_text(130);
    drain_and_set_mode(1'b0);
    tx_idle_pct = 63;
    rx_idle_pct = 29;
    random_text(130);
    drain_and_set_mode(1'b1);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_off    = 1'b1;
    random_text(130);

    while (sb.expected_text.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d bytes in %0d texts, checked %0d output transfers.",
             sb.n_in, sb.n_texts, sb.n_out);
    $display("Both rune modes, all escape forms, stalls and a long output hold-off.");
    if (sb.errors == 0 && sb.expected_text.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
